@@ hw/rtl/pewm_pkg.sv @@
package pewm_pkg;

  localparam int unsigned BaseBits = 2;
  localparam int unsigned CodeBits = 5;
  localparam int unsigned LenBits = 4;
  localparam int unsigned CodesBits = 60;
  localparam int unsigned CfgDataBits = 60;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned OutPosBits = 16;
  localparam logic [CodeBits:0] StopMark = 6'd32;

  localparam logic [CfgIdxBits-1:0] CfgPeptideLength = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgPeptideCodes = 1'b1;

  function automatic logic [CodeBits:0] codon_lookup(input logic [5:0] idx);
    logic [CodeBits:0] aa;
    case (idx)
      6'd0, 6'd2: aa = 6'd8;
      6'd1, 6'd3: aa = 6'd11;
      6'd4, 6'd5, 6'd6, 6'd7: aa = 6'd16;
      6'd8, 6'd10: aa = 6'd14;
      6'd9, 6'd11: aa = 6'd15;
      6'd12, 6'd13, 6'd15: aa = 6'd7;
      6'd14: aa = 6'd10;
      6'd16, 6'd18: aa = 6'd13;
      6'd17, 6'd19: aa = 6'd6;
      6'd20, 6'd21, 6'd22, 6'd23: aa = 6'd12;
      6'd24, 6'd25, 6'd26, 6'd27: aa = 6'd14;
      6'd28, 6'd29, 6'd30, 6'd31: aa = 6'd9;
      6'd32, 6'd34: aa = 6'd3;
      6'd33, 6'd35: aa = 6'd2;
      6'd36, 6'd37, 6'd38, 6'd39: aa = 6'd0;
      6'd40, 6'd41, 6'd42, 6'd43: aa = 6'd5;
      6'd44, 6'd45, 6'd46, 6'd47: aa = 6'd17;
      6'd48, 6'd50: aa = StopMark;
      6'd49, 6'd51: aa = 6'd19;
      6'd52, 6'd53, 6'd54, 6'd55: aa = 6'd15;
      6'd56: aa = StopMark;
      6'd57, 6'd59: aa = 6'd1;
      6'd58: aa = 6'd18;
      6'd60, 6'd62: aa = 6'd9;
      6'd61, 6'd63: aa = 6'd4;
      default: aa = StopMark;
    endcase
    return aa;
  endfunction

  typedef struct packed {
    logic [OutPosBits-1:0] pos;
    logic                  fwd;
    logic                  rev;
  } pewm_res_t;

endpackage

@@ hw/rtl/pewm_front.sv @@
module pewm_front import pewm_pkg::*; #(
  parameter int unsigned MaxPeptide = 12,
  parameter int unsigned PositionBits = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [BaseBits-1:0]        base_i,
  input  logic                       sequence_end_i,
  input  logic [LenBits-1:0]         len_i,
  output logic                       vld_o,
  output logic [3*MaxPeptide*2-1:0]  hist_o,
  output logic [PositionBits-1:0]    seen_o
);

  localparam int unsigned Depth = 3 * MaxPeptide;
  localparam logic [PositionBits-1:0] PosMax = '1;

  logic [Depth*2-1:0] hist_q, hist_d;
  logic [PositionBits-1:0] seen_q, seen_d, seen_inc;
  logic [Depth*2-1:0] hist_o_q;
  logic [PositionBits-1:0] seen_o_q;
  logic vld_q;

  assign seen_inc = (seen_q != PosMax) ? seen_q + 1'b1 : seen_q;

  always_comb begin
    hist_d = hist_q;
    seen_d = seen_q;
    if (take_i) begin
      if (sequence_end_i) begin
        hist_d = '0;
        seen_d = '0;
      end else begin
        hist_d = {hist_q[Depth*2-3:0], base_i};
        seen_d = seen_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      seen_q <= '0;
      vld_q <= 1'b0;
    end else begin
      hist_q <= hist_d;
      seen_q <= seen_d;
      vld_q <= take_i && (len_i != '0) && (32'(len_i) <= MaxPeptide);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      hist_o_q <= {hist_q[Depth*2-3:0], base_i};
      seen_o_q <= seen_inc;
    end
  end

  assign vld_o = vld_q;
  assign hist_o = hist_o_q;
  assign seen_o = seen_o_q;

endmodule

@@ hw/rtl/pewm_back.sv @@
module pewm_back import pewm_pkg::*; #(
  parameter int unsigned MaxPeptide = 12,
  parameter int unsigned PositionBits = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [3*MaxPeptide*2-1:0]  hist_i,
  input  logic [PositionBits-1:0]    seen_i,
  input  logic [LenBits-1:0]         len_i,
  input  logic [CodesBits-1:0]       codes_i,
  output logic                       vld_o,
  output pewm_res_t                  res_o
);

  localparam int unsigned Depth = 3 * MaxPeptide;

  logic [MaxPeptide-1:0] fok, rok, used;
  logic [PositionBits-1:0] n_ext;
  logic fwd, rev, full;
  logic vld_q;
  pewm_res_t res_q;

  // Entry k of the history is hist_i[2k+1:2k], entry 0 the newest.
  always_comb begin
    n_ext = PositionBits'(3 * 32'(len_i));
    for (int j = 0; j < MaxPeptide; j++) begin
      logic [1:0] f0, f1, f2, r0, r1, r2;
      logic [CodeBits:0] fa, ra;
      logic [CodeBits-1:0] tgt;
      int fi;
      fi = 3 * 32'(len_i) - 1 - 3 * j;
      used[j] = (j < 32'(len_i));
      if (fi >= 2 && fi < Depth) begin
        f0 = hist_i[2*fi +: 2];
        f1 = hist_i[2*(fi-1) +: 2];
        f2 = hist_i[2*(fi-2) +: 2];
      end else begin
        f0 = '0; f1 = '0; f2 = '0;
      end
      r0 = 2'd3 - hist_i[2*(3*j) +: 2];
      r1 = 2'd3 - hist_i[2*(3*j+1) +: 2];
      r2 = 2'd3 - hist_i[2*(3*j+2) +: 2];
      tgt = codes_i[CodeBits*j +: CodeBits];
      fa = codon_lookup({f0, f1, f2});
      ra = codon_lookup({r0, r1, r2});
      fok[j] = (fa != StopMark) && (fa[CodeBits-1:0] == tgt) && (fa[CodeBits] == 1'b0);
      rok[j] = (ra != StopMark) && (ra[CodeBits-1:0] == tgt) && (ra[CodeBits] == 1'b0);
    end
    fwd = &(fok | ~used);
    rev = &(rok | ~used);
    full = seen_i >= n_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i && full && (fwd || rev);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.pos <= OutPosBits'(seen_i - n_ext);
    res_q.fwd <= fwd;
    res_q.rev <= rev;
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

@@ hw/rtl/pewm_fifo.sv @@
module pewm_fifo import pewm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pewm_res_t data_i,
  input  logic      pop_i,
  output logic      valid_o,
  output pewm_res_t data_o,
  output logic [2:0] count_o
);

  pewm_res_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign valid_o = cnt_q != '0;
  assign data_o = mem_q[rp_q];
  assign count_o = cnt_q;

endmodule

@@ hw/rtl/peptide_encoding_window_matcher_unit.sv @@
// Results pass the front register, the back register and the queue.
// One base per cycle while stall_o is low; all codons are checked in parallel.
// A four-entry queue absorbs output stalls; stall_o rises when it could overflow.
// Reset (rst_ni low, asynchronous) clears history, position, queue and sets
// peptide_length to 1 and peptide_codes to 0.
module peptide_encoding_window_matcher_unit import pewm_pkg::*; #(
  parameter int unsigned MaxPeptide = 12,
  parameter int unsigned PositionBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic [BaseBits-1:0]    base_i,
  input  logic                   sequence_end_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic [OutPosBits-1:0]  start_position_o,
  output logic                   forward_match_o,
  output logic                   reverse_match_o
);

  logic [LenBits-1:0] len_q;
  logic [CodesBits-1:0] codes_q;
  logic take, fvld, bvld, qvld, pop;
  logic [3*MaxPeptide*2-1:0] hist;
  logic [PositionBits-1:0] seen;
  logic [2:0] cnt;
  pewm_res_t bres, qres;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenBits'(1);
      codes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPeptideLength: len_q <= cfg_data_i[LenBits-1:0];
        CfgPeptideCodes: codes_q <= cfg_data_i[CodesBits-1:0];
        default: ;
      endcase
    end
  end

  // Two results may be in flight behind the queue contents.
  assign stall_o = (cnt >= 3'd2);
  assign take = valid_i && !stall_o;
  assign pop = qvld && !stall_i;

  pewm_front #(.MaxPeptide(MaxPeptide), .PositionBits(PositionBits)) u_front (
    .clk_i, .rst_ni, .take_i(take), .base_i, .sequence_end_i, .len_i(len_q),
    .vld_o(fvld), .hist_o(hist), .seen_o(seen)
  );

  pewm_back #(.MaxPeptide(MaxPeptide), .PositionBits(PositionBits)) u_back (
    .clk_i, .rst_ni, .vld_i(fvld), .hist_i(hist), .seen_i(seen), .len_i(len_q),
    .codes_i(codes_q), .vld_o(bvld), .res_o(bres)
  );

  pewm_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(bvld), .data_i(bres), .pop_i(pop),
    .valid_o(qvld), .data_o(qres), .count_o(cnt)
  );

  assign valid_o = qvld;
  assign start_position_o = qres.pos;
  assign forward_match_o = qres.fwd;
  assign reverse_match_o = qres.rev;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cnt == 3'd4 && bvld && !pop)) else $error("result queue overflow");
  a_flag_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qvld |-> (qres.fwd || qres.rev)) else $error("result without match flag");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt >= 3'd2) |-> !take) else $error("accepted while queue nearly full");

endmodule

@@ tb/sv/pewm_checker.sv @@
`timescale 1ns / 100ps

module pewm_checker import pewm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   valid_i,
  input  logic                   stall_o,
  input  logic [BaseBits-1:0]    base_i,
  input  logic                   sequence_end_i,
  input  logic                   valid_o,
  input  logic                   stall_i,
  input  logic [OutPosBits-1:0]  start_position_o,
  input  logic                   forward_match_o,
  input  logic                   reverse_match_o,
  output int                     fail_count,
  output int                     pending
);

  localparam int unsigned HistDepth = 36;
  localparam logic [5:0] NoAmino = 6'd32;

  localparam logic [5:0] AminoTable [64] = '{
    6'd8, 6'd11, 6'd8, 6'd11, 6'd16, 6'd16, 6'd16, 6'd16,
    6'd14, 6'd15, 6'd14, 6'd15, 6'd7, 6'd7, 6'd10, 6'd7,
    6'd13, 6'd6, 6'd13, 6'd6, 6'd12, 6'd12, 6'd12, 6'd12,
    6'd14, 6'd14, 6'd14, 6'd14, 6'd9, 6'd9, 6'd9, 6'd9,
    6'd3, 6'd2, 6'd3, 6'd2, 6'd0, 6'd0, 6'd0, 6'd0,
    6'd5, 6'd5, 6'd5, 6'd5, 6'd17, 6'd17, 6'd17, 6'd17,
    NoAmino, 6'd19, NoAmino, 6'd19, 6'd15, 6'd15, 6'd15, 6'd15,
    NoAmino, 6'd1, 6'd18, 6'd1, 6'd9, 6'd4, 6'd9, 6'd4
  };

  logic [1:0]           history [HistDepth];
  logic [15:0]          seen;
  logic [LenBits-1:0]   pep_len;
  logic [CodesBits-1:0] pep_codes;
  pewm_res_t            match_q [$];

  function automatic logic [5:0] amino_of(input logic [5:0] codon);
    return AminoTable[codon];
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic predict_match(input logic [1:0] b, input logic last);
    int        n;
    logic      fwd;
    logic      rev;
    logic [5:0] aa;
    pewm_res_t r;
    for (int k = HistDepth - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = b;
    if (seen != 16'hffff) seen++;
    if (pep_len >= 1 && pep_len <= 12) begin
      n = 3 * pep_len;
      if (seen >= n) begin
        fwd = 1'b1;
        rev = 1'b1;
        for (int j = 0; j < pep_len; j++) begin
          aa = amino_of({history[n-1-3*j], history[n-2-3*j], history[n-3-3*j]});
          if (aa == NoAmino || aa != {1'b0, pep_codes[5*j +: 5]}) fwd = 1'b0;
          aa = amino_of({~history[3*j], ~history[3*j+1], ~history[3*j+2]});
          if (aa == NoAmino || aa != {1'b0, pep_codes[5*j +: 5]}) rev = 1'b0;
        end
        if (fwd || rev) begin
          r.pos = seen - 16'(n);
          r.fwd = fwd;
          r.rev = rev;
          match_q.insert(match_q.size(), r);
        end
      end
    end
    if (last) begin
      foreach (history[k]) history[k] = 2'd0;
      seen = '0;
    end
  endtask

  task automatic compare_match();
    pewm_res_t w;
    if (match_q.size() == 0) begin
      report($sformatf("unexpected item pos=%0d", start_position_o));
    end else begin
      w = match_q.pop_front();
      if (start_position_o !== w.pos)
        report($sformatf("start_position %0d, want %0d", start_position_o, w.pos));
      if (forward_match_o !== w.fwd)
        report($sformatf("forward_match %0b, want %0b", forward_match_o, w.fwd));
      if (reverse_match_o !== w.rev)
        report($sformatf("reverse_match %0b, want %0b", reverse_match_o, w.rev));
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (history[k]) history[k] = 2'd0;
      seen = '0;
      pep_len = 4'd1;
      pep_codes = '0;
      match_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgPeptideLength) pep_len = cfg_data_i[LenBits-1:0];
        else if (cfg_idx_i == CfgPeptideCodes) pep_codes = cfg_data_i[CodesBits-1:0];
      end
      if (valid_o && !stall_i) compare_match();
      if (valid_i && !stall_o) predict_match(base_i, sequence_end_i);
    end
    pending = match_q.size();
  end

endmodule

@@ tb/sv/tb_peptide_encoding_window_matcher_unit.sv @@
`timescale 1ns / 100ps

module tb_peptide_encoding_window_matcher_unit import pewm_pkg::*;;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = CfgPeptideLength;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic                   valid_i = 1'b0;
  logic                   stall_o;
  logic [BaseBits-1:0]    base_i = '0;
  logic                   sequence_end_i = 1'b0;
  logic                   valid_o;
  logic                   stall_i = 1'b0;
  logic [OutPosBits-1:0]  start_position_o;
  logic                   forward_match_o;
  logic                   reverse_match_o;
  int                     fail_count;
  int                     pending;

  int                     idle_cycles = 0;
  bit                     send_quiet = 1'b0;
  logic [5:0]             codon_set [12];
  logic [CodesBits-1:0]   target_codes;

  peptide_encoding_window_matcher_unit u_dut (.*);

  pewm_checker u_chk (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int n;
    forever begin
      n = $urandom_range(20, 300);
      if ($urandom_range(0, 3) == 0) begin
        repeat (n) @(posedge clk_i) stall_i <= 1'b0;
      end else begin
        while (n > 0) begin
          @(posedge clk_i);
          stall_i <= ($urandom_range(0, 99) < 30);
          n--;
          if ($urandom_range(0, 99) < 3) begin
            @(posedge clk_i);
            stall_i <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clk_i);
            stall_i <= 1'b0;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("tb_peptide_encoding_window_matcher_unit: FAIL");
      $finish;
    end
  end

  task automatic send_base(input logic [1:0] b, input logic last);
    int g;
    valid_i <= 1'b1;
    base_i <= b;
    sequence_end_i <= last;
    do @(posedge clk_i); while (stall_o);
    g = send_quiet ? 0 : random_gap();
    if (g > 0) begin
      valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    if (valid_i) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic pick_codons(input int len, input bit keep_codes);
    logic [5:0] c;
    for (int j = 0; j < len; j++) begin
      do c = 6'($urandom_range(0, 63));
      while (u_chk.amino_of(c) == 6'd32 ||
             (keep_codes && target_codes[5*j +: 5] < 5'd20 &&
              u_chk.amino_of(c) != {1'b0, target_codes[5*j +: 5]}));
      codon_set[j] = c;
      if (!keep_codes) target_codes[5*j +: 5] = u_chk.amino_of(c);
    end
  endtask

  task automatic send_peptide(input int len, input bit reverse);
    logic [1:0] s [36];
    for (int j = 0; j < len; j++) begin
      s[3*j] = codon_set[j][5:4];
      s[3*j+1] = codon_set[j][3:2];
      s[3*j+2] = codon_set[j][1:0];
    end
    if (!reverse) for (int i = 0; i < 3 * len; i++) send_base(s[i], 1'b0);
    else for (int i = 3 * len - 1; i >= 0; i--) send_base(~s[i], 1'b0);
  endtask

  initial begin
    int len;
    int cnt;
    int lens [6];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_base(2'd2, 1'b0);
    send_base(2'd1, 1'b0);
    send_base(2'd0, 1'b0);
    send_base(2'd3, 1'b0);
    send_base(2'd2, 1'b0);
    send_base(2'd1, 1'b0);
    send_base(2'd3, 1'b0);
    send_base(2'd0, 1'b0);
    send_base(2'd0, 1'b0);
    send_base(2'd3, 1'b0);
    send_base(2'd2, 1'b1);
    send_base(2'd2, 1'b0);
    send_base(2'd1, 1'b1);
    drain();
    write_reg(CfgPeptideCodes, {12{5'd31}});
    write_reg(CfgPeptideLength, CfgDataBits'(0));
    for (int i = 0; i < 6; i++) send_base(2'(i), 1'b0);
    drain();
    write_reg(CfgPeptideLength, CfgDataBits'(15));
    for (int i = 0; i < 6; i++) send_base(2'(3 - i), i == 5);
    drain();
    target_codes = '0;
    pick_codons(12, 1'b0);
    write_reg(CfgPeptideCodes, target_codes);
    write_reg(CfgPeptideLength, CfgDataBits'(12));
    send_peptide(12, 1'b0);
    send_peptide(12, 1'b1);
    drain();

    lens = '{1, 12, 0, 13, 2, 3};
    for (int p = 0; p < 14; p++) begin
      len = (p < 6) ? lens[p] : $urandom_range(1, 12);
      target_codes = CodesBits'({$urandom, $urandom});
      pick_codons((len >= 1 && len <= 12) ? len : 12, 1'b0);
      if ($urandom_range(0, 4) == 0)
        target_codes[5*$urandom_range(0, len > 0 && len < 13 ? len - 1 : 0) +: 5] =
          5'($urandom_range(20, 31));
      drain();
      write_reg(CfgPeptideLength, CfgDataBits'(len));
      write_reg(CfgPeptideCodes, target_codes);
      send_quiet = ($urandom_range(0, 3) == 0);
      cnt = 0;
      while (cnt < 110) begin
        if ($urandom_range(0, 99) < 60 && len >= 1 && len <= 12) begin
          pick_codons(len, 1'b1);
          send_peptide(len, 1'($urandom_range(0, 1)));
          cnt += 3 * len;
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_base(2'($urandom_range(0, 3)), $urandom_range(0, 49) == 0);
            cnt++;
          end
        end
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    write_reg(CfgPeptideLength, CfgDataBits'(1));
    write_reg(CfgPeptideCodes, CodesBits'($urandom_range(0, 19)));
    send_quiet = 1'b1;
    for (int i = 0; i < 6; i++) send_base(2'($urandom_range(0, 3)), i == 5);
    send_quiet = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_peptide_encoding_window_matcher_unit: PASS");
    end else begin
      $display("tb_peptide_encoding_window_matcher_unit: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pewm_pkg.sv
hw/rtl/pewm_front.sv
hw/rtl/pewm_back.sv
hw/rtl/pewm_fifo.sv
hw/rtl/peptide_encoding_window_matcher_unit.sv
tb/sv/pewm_checker.sv
tb/sv/tb_peptide_encoding_window_matcher_unit.sv
